[rtl/fpfa_pkg.sv]
`timescale 1ns / 1ps
package fpfa_pkg;

  localparam int unsigned IDX_W  = 4;
  localparam int unsigned SIZE_W = 16;
  localparam int unsigned PID_W  = 8;
  localparam int unsigned POL_W  = 2;

  localparam logic [PID_W-1:0] NO_OWNER = '1;

  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  localparam logic OP_DEFINE   = 1'b0;
  localparam logic OP_ALLOCATE = 1'b1;

  // Search record handed from cell to cell.
  typedef struct packed {
    logic              active;
    logic [POL_W-1:0]  policy;
    logic [SIZE_W-1:0] req;
    logic              found;
    logic [IDX_W-1:0]  pick;
    logic [SIZE_W-1:0] left;
  } search_rec_t;

  // Define write broadcast to all cells.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] size;
  } define_cmd_t;

  // Allocation commit broadcast to all cells.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  idx;
    logic [PID_W-1:0]  pid;
  } commit_cmd_t;

  function automatic logic fit_better(input logic [POL_W-1:0]  policy,
                                      input logic              found,
                                      input logic [SIZE_W-1:0] left,
                                      input logic [SIZE_W-1:0] pick_left);
    logic res;
    if (!found) begin
      res = 1'b1;
    end else begin
      unique case (policy)
        POL_BEST:  res = left < pick_left;
        POL_WORST: res = left > pick_left;
        default:   res = 1'b0;
      endcase
    end
    return res;
  endfunction

endpackage

[rtl/fpfa_in_if.sv]
`timescale 1ns / 1ps
interface fpfa_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [fpfa_pkg::IDX_W-1:0]   target_index;
  logic [fpfa_pkg::SIZE_W-1:0]  new_block_size;
  logic [fpfa_pkg::SIZE_W-1:0]  request_size;
  logic [fpfa_pkg::PID_W-1:0]   process_id;

  modport source (output valid, operation, target_index, new_block_size, request_size,
                  process_id, input ready);
  modport sink (input valid, operation, target_index, new_block_size, request_size,
                process_id, output ready);
endinterface

[rtl/fpfa_out_if.sv]
`timescale 1ns / 1ps
interface fpfa_out_if;
  logic                         valid;
  logic                         ready;
  logic                         granted;
  logic [fpfa_pkg::IDX_W-1:0]   chosen_index;
  logic [fpfa_pkg::SIZE_W-1:0]  leftover;

  modport source (output valid, granted, chosen_index, leftover, input ready);
  modport sink (input valid, granted, chosen_index, leftover, output ready);
endinterface

[rtl/fpfa_cell.sv]
`timescale 1ns / 1ps
module fpfa_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fpfa_pkg::define_cmd_t def_cmd,
  input  fpfa_pkg::commit_cmd_t commit_cmd,
  input  fpfa_pkg::search_rec_t rec_in,
  output fpfa_pkg::search_rec_t rec_out
);
  import fpfa_pkg::*;

  // Only the first sixteen cells are addressable by a define.
  localparam logic            ADDRESSABLE = (IDX < 16);
  localparam logic [IDX_W-1:0] MY_IDX     = IDX_W'(IDX);

  logic [SIZE_W-1:0] size;
  logic              valid;
  logic              taken;
  logic [PID_W-1:0]  owner;

  logic              def_hit;
  logic              commit_hit;
  logic              fits;
  logic [SIZE_W-1:0] left;
  logic              take;
  search_rec_t       rec_next;

  assign def_hit    = ADDRESSABLE && def_cmd.we && (def_cmd.idx == MY_IDX);
  assign commit_hit = ADDRESSABLE && commit_cmd.we && (commit_cmd.idx == MY_IDX);

  always_ff @(posedge clk) begin
    if (def_hit) begin
      size <= def_cmd.size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      taken <= 1'b0;
      owner <= NO_OWNER;
    end else if (def_hit) begin
      valid <= 1'b1;
      taken <= 1'b0;
      owner <= NO_OWNER;
    end else if (commit_hit) begin
      taken <= 1'b1;
      owner <= commit_cmd.pid;
    end
  end

  // Compare this partition against the best candidate so far.
  always_comb begin
    fits     = rec_in.active && valid && !taken && (size >= rec_in.req);
    left     = size - rec_in.req;
    take     = fits && fit_better(rec_in.policy, rec_in.found, left, rec_in.left);
    rec_next = rec_in;
    if (take) begin
      rec_next.found = 1'b1;
      rec_next.pick  = MY_IDX;
      rec_next.left  = left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_out <= '0;
    end else begin
      rec_out <= rec_next;
    end
  end
endmodule

[rtl/fixed_partition_fit_allocator_top.sv]
`timescale 1ns / 1ps
// Fixed-partition allocator with first, best and worst fit placement.
//
// Channels: in_ch carries one transaction per item (define a partition or
// allocate a request); out_ch returns exactly one result per item. Both use
// valid/ready, a transaction moves when both are high. cfg_we/cfg_data write
// the fit policy (0 first, 1 best, 2 worst, 3 acts as first). The user must
// write it only while idle; the block itself does not enforce this.
//
// Path: a define's result is parked in a result register and then moved to
// the output register. An allocate's record passes a start register and a
// chain of NUM_PARTS cells, one cell per cycle, then is parked likewise.
// One item at a time: in_ch.ready stays low until the parked result moves on.
//
// Reset clears all partitions to invalid and free, owners to none and the
// policy to first fit. When the receiver stalls, the finished result holds
// in the output register; one more result may wait internally, and then
// in_ch.ready stays low until the output drains.
module fixed_partition_fit_allocator_top #(
  parameter int unsigned NUM_PARTS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [fpfa_pkg::POL_W-1:0]  cfg_data,
  fpfa_in_if.sink                     in_ch,
  fpfa_out_if.source                  out_ch
);
  import fpfa_pkg::*;

  logic [POL_W-1:0] fit_policy;

  logic busy;   // search in flight
  logic pend;   // result waiting for the output register

  logic              res_granted;
  logic [IDX_W-1:0]  res_index;
  logic [SIZE_W-1:0] res_left;
  logic [PID_W-1:0]  alloc_pid;

  logic        in_fire;
  logic        out_free;
  logic        search_done;
  logic        def_in_range;
  define_cmd_t def_cmd;
  commit_cmd_t commit_cmd;
  search_rec_t start_rec;
  search_rec_t chain [NUM_PARTS+1];

  assign in_ch.ready = !busy && !pend;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_ch.valid || out_ch.ready;

  assign def_in_range = 32'(in_ch.target_index) < NUM_PARTS;

  // Policy register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= POL_FIRST;
    end else if (cfg_we) begin
      fit_policy <= cfg_data;
    end
  end

  // Define writes straight into the addressed cell at acceptance.
  always_comb begin
    def_cmd.we   = in_fire && (in_ch.operation == OP_DEFINE) && def_in_range;
    def_cmd.idx  = in_ch.target_index;
    def_cmd.size = in_ch.new_block_size;
  end

  // Launch a search record into the head of the chain for an allocate.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_rec <= '0;
    end else begin
      start_rec.active <= in_fire && (in_ch.operation == OP_ALLOCATE);
      if (in_fire) begin
        start_rec.policy <= fit_policy;
        start_rec.req    <= in_ch.request_size;
        start_rec.found  <= 1'b0;
        start_rec.pick   <= '0;
        start_rec.left   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      alloc_pid <= in_ch.process_id;
    end
  end

  assign chain[0] = start_rec;

  for (genvar i = 0; i < NUM_PARTS; i++) begin : g_cell
    fpfa_cell #(
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .def_cmd    (def_cmd),
      .commit_cmd (commit_cmd),
      .rec_in     (chain[i]),
      .rec_out    (chain[i+1])
    );
  end

  // The record leaving the last cell carries the winner; commit it.
  assign search_done = chain[NUM_PARTS].active;

  always_comb begin
    commit_cmd.we  = search_done && chain[NUM_PARTS].found;
    commit_cmd.idx = chain[NUM_PARTS].pick;
    commit_cmd.pid = alloc_pid;
  end

  // Sequencing: busy while a record travels, then park; a define parks at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pend <= 1'b0;
    end else begin
      if (in_fire && (in_ch.operation == OP_ALLOCATE)) begin
        busy <= 1'b1;
      end else if (search_done) begin
        busy <= 1'b0;
      end
      if (in_fire && (in_ch.operation == OP_DEFINE)) begin
        pend <= 1'b1;
      end else if (search_done) begin
        pend <= 1'b1;
      end else if (pend && out_free) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_ch.operation == OP_DEFINE)) begin
      res_granted <= def_in_range;
      res_index   <= def_in_range ? in_ch.target_index : '0;
      res_left    <= def_in_range ? in_ch.new_block_size : '0;
    end else if (search_done) begin
      res_granted <= chain[NUM_PARTS].found;
      res_index   <= chain[NUM_PARTS].found ? chain[NUM_PARTS].pick : '0;
      res_left    <= chain[NUM_PARTS].found ? chain[NUM_PARTS].left : '0;
    end
  end

  // Output register: advance the parked result when the slot frees.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_free) begin
      out_ch.valid <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pend) begin
      out_ch.granted      <= res_granted;
      out_ch.chosen_index <= res_index;
      out_ch.leftover     <= res_left;
    end
  end
endmodule
